// ----- rtl/ultrasonic_range_scanner_core_macros.svh -----
// assertion macros for the ultrasonic range scanner
`ifndef ULTRASONIC_RANGE_SCANNER_CORE_MACROS_SVH
`define ULTRASONIC_RANGE_SCANNER_CORE_MACROS_SVH

`ifndef SYNTH

// checked while out of reset
`define URS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define URS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define URS_ASSERT(lbl, clk, rst_n, prop, msg)
`define URS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/urs_pkg.sv -----
package urs_pkg;

    localparam int DIST_W = 18;
    localparam logic [DIST_W-1:0] DIST_MAX = 18'h3FFFF;

    localparam logic [15:0] PERIOD_RESET = 16'd20000;

    // echo ticks to 1/16 cm is ticks * 80 / 29
    localparam int DIV_REM_W = 5;
    localparam logic [DIV_REM_W-1:0] DIV_DEN = 5'd29;
    localparam logic [DIV_REM_W:0] STEP_REM = 6'd22;  // 80 mod 29
    localparam int STEP_QUO = 2;                      // 80 div 29

    typedef enum logic [2:0] {
        PH_TRIG_START = 3'd0,
        PH_TRIG_LOW   = 3'd1,
        PH_RELEASE    = 3'd2,
        PH_WAIT_EDGE  = 3'd3,
        PH_COUNT      = 3'd4,
        PH_PERIOD     = 3'd5
    } phase_t;

    typedef logic [1:0] sensor_t;

    localparam sensor_t SENSOR_LEFT   = 2'd0;
    localparam sensor_t SENSOR_MIDDLE = 2'd1;
    localparam sensor_t SENSOR_RIGHT  = 2'd2;

    typedef struct packed {
        logic              en;
        sensor_t           idx;
        logic [DIST_W-1:0] dist_val;
    } store_t;

endpackage

// ----- rtl/urs_seq.sv -----
module urs_seq #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [2:0]        echo_levels,
    input  logic [15:0]       period_ticks,
    output urs_pkg::sensor_t  sensor,
    output urs_pkg::phase_t   phase,
    output urs_pkg::store_t   store
);

    localparam int QW = COUNT_WIDTH + 2;
    localparam int EW = (QW > urs_pkg::DIST_W) ? QW : urs_pkg::DIST_W;
    localparam int PW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] TICK_MAX = {COUNT_WIDTH{1'b1}};

    urs_pkg::phase_t phase_reg, phase_next;
    urs_pkg::sensor_t sensor_reg, sensor_next;
    logic last_echo_reg, last_echo_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    // running quotient and remainder of tick_reg * 80 / 29
    logic [QW-1:0] quo_reg, quo_next;
    logic [urs_pkg::DIV_REM_W-1:0] rem_reg, rem_next;

    logic [1:0] sel;
    logic echo;
    logic edge_seen;
    logic zero_count;
    logic bump;
    logic [COUNT_WIDTH-1:0] tick_base;
    logic [QW-1:0] quo_base;
    logic [urs_pkg::DIV_REM_W-1:0] rem_base;
    logic [urs_pkg::DIV_REM_W:0] rem_sum;
    logic [EW-1:0] quo_ext;
    logic [urs_pkg::DIST_W-1:0] dist_sat;
    logic period_done;

    assign sel = (sensor_reg > urs_pkg::SENSOR_RIGHT) ? urs_pkg::SENSOR_RIGHT : sensor_reg;
    assign echo = echo_levels[sel];
    assign edge_seen = echo != last_echo_reg;
    assign period_done = PW'(tick_reg) >= PW'(period_ticks);

    assign quo_ext = EW'(quo_reg);
    assign dist_sat = (quo_ext > EW'(urs_pkg::DIST_MAX)) ? urs_pkg::DIST_MAX
                                                          : quo_ext[urs_pkg::DIST_W-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        sensor_next = sensor_reg;
        last_echo_next = last_echo_reg;
        zero_count = 1'b0;
        bump = 1'b1;
        store.en = 1'b0;
        store.idx = sensor_reg;
        store.dist_val = dist_sat;

        case (phase_reg)
            urs_pkg::PH_TRIG_START:
            begin
                zero_count = 1'b1;
                phase_next = urs_pkg::PH_TRIG_LOW;
            end
            urs_pkg::PH_TRIG_LOW:
            begin
                phase_next = urs_pkg::PH_RELEASE;
            end
            urs_pkg::PH_RELEASE:
            begin
                phase_next = urs_pkg::PH_WAIT_EDGE;
            end
            urs_pkg::PH_WAIT_EDGE:
            begin
                if (edge_seen)
                begin
                    zero_count = 1'b1;
                    phase_next = urs_pkg::PH_COUNT;
                end
                last_echo_next = echo;
            end
            urs_pkg::PH_COUNT:
            begin
                if (edge_seen)
                begin
                    store.en = sensor_reg <= urs_pkg::SENSOR_RIGHT;
                    phase_next = urs_pkg::PH_PERIOD;
                end
                last_echo_next = echo;
            end
            urs_pkg::PH_PERIOD:
            begin
                if (period_done)
                begin
                    sensor_next = (sensor_reg >= urs_pkg::SENSOR_RIGHT) ? urs_pkg::SENSOR_LEFT
                                                                        : sensor_reg + 2'd1;
                    zero_count = 1'b1;
                    bump = 1'b0;
                    phase_next = urs_pkg::PH_TRIG_START;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        tick_base = zero_count ? '0 : tick_reg;
        quo_base = zero_count ? '0 : quo_reg;
        rem_base = zero_count ? '0 : rem_reg;
        rem_sum = {1'b0, rem_base} + urs_pkg::STEP_REM;

        tick_next = tick_base;
        quo_next = quo_base;
        rem_next = rem_base;
        // saturating tick counter, quotient follows it step for step
        if (bump && tick_base != TICK_MAX)
        begin
            tick_next = tick_base + COUNT_WIDTH'(1);
            if (rem_sum >= {1'b0, urs_pkg::DIV_DEN})
            begin
                rem_next = urs_pkg::DIV_REM_W'(rem_sum - {1'b0, urs_pkg::DIV_DEN});
                quo_next = quo_base + QW'(urs_pkg::STEP_QUO + 1);
            end
            else
            begin
                rem_next = rem_sum[urs_pkg::DIV_REM_W-1:0];
                quo_next = quo_base + QW'(urs_pkg::STEP_QUO);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= urs_pkg::PH_TRIG_START;
            sensor_reg <= urs_pkg::SENSOR_LEFT;
            last_echo_reg <= 1'b0;
            tick_reg <= '0;
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            sensor_reg <= sensor_next;
            last_echo_reg <= last_echo_next;
            tick_reg <= tick_next;
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign sensor = sensor_reg;
    assign phase = phase_reg;

endmodule

// ----- rtl/urs_dist_store.sv -----
module urs_dist_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  urs_pkg::store_t              store,
    output logic                         distance_valid,
    output logic [urs_pkg::DIST_W-1:0]   distance_left,
    output logic [urs_pkg::DIST_W-1:0]   distance_middle,
    output logic [urs_pkg::DIST_W-1:0]   distance_right
);

    logic valid_reg;
    logic [urs_pkg::DIST_W-1:0] left_reg, middle_reg, right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            left_reg <= '0;
            middle_reg <= '0;
            right_reg <= '0;
        end
        else if (step)
        begin
            valid_reg <= store.en;
            if (store.en)
            begin
                case (store.idx)
                    urs_pkg::SENSOR_LEFT:   left_reg <= store.dist_val;
                    urs_pkg::SENSOR_MIDDLE: middle_reg <= store.dist_val;
                    urs_pkg::SENSOR_RIGHT:  right_reg <= store.dist_val;
                    default:                left_reg <= left_reg;
                endcase
            end
        end
    end

    assign distance_valid = valid_reg;
    assign distance_left = left_reg;
    assign distance_middle = middle_reg;
    assign distance_right = right_reg;

endmodule

// ----- rtl/ultrasonic_range_scanner_core.sv -----
// Scans three ultrasonic rangers in turn, one 10 us tick beat per input. Each accepted
// tick yields exactly one result beat in the next cycle, and a new tick is accepted every
// cycle while the output is taken (in_ready drops only while a result waits unread).
// The whole phase step is combinational logic between the scan state and the result
// registers; the echo length is turned into 1/16 cm by a running quotient kept alongside
// the tick counter, so no divider is involved. The result carries the trigger drive, the
// sensor served, a flag for a freshly stored distance and the latest three distances.
// A sensor that never answers holds the scan in its echo wait or count phase. The user
// must write period_ticks via cfg_wr_en/cfg_wr_data only while idle; this is not enforced.
`include "ultrasonic_range_scanner_core_macros.svh"

module ultrasonic_range_scanner_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [15:0]                  cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   echo_levels,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   active_sensor,
    output logic                         trigger_driven,
    output logic                         trigger_high,
    output logic                         distance_valid,
    output logic [urs_pkg::DIST_W-1:0]   distance_left,
    output logic [urs_pkg::DIST_W-1:0]   distance_middle,
    output logic [urs_pkg::DIST_W-1:0]   distance_right
);

    logic [15:0] period_reg;
    logic out_valid_reg, out_valid_next;
    logic step;
    urs_pkg::sensor_t sensor;
    urs_pkg::phase_t phase;
    urs_pkg::store_t store;

    assign in_ready = !out_valid_reg || out_ready;
    assign step = in_valid && in_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= urs_pkg::PERIOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                period_reg <= cfg_wr_data;
            out_valid_reg <= out_valid_next;
        end
    end

    urs_seq #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_seq (
        .clk(clk),
        .rst_n(rst_n),
        .step(step),
        .echo_levels(echo_levels),
        .period_ticks(period_reg),
        .sensor(sensor),
        .phase(phase),
        .store(store)
    );

    // state and store registers hold the last beat's result until the next accept
    urs_dist_store u_store (
        .clk(clk),
        .rst_n(rst_n),
        .step(step),
        .store(store),
        .distance_valid(distance_valid),
        .distance_left(distance_left),
        .distance_middle(distance_middle),
        .distance_right(distance_right)
    );

    assign out_valid = out_valid_reg;
    assign active_sensor = sensor;
    assign trigger_driven = (phase == urs_pkg::PH_TRIG_LOW) || (phase == urs_pkg::PH_RELEASE);
    assign trigger_high = phase == urs_pkg::PH_TRIG_LOW;

    `URS_ASSERT_ALWAYS(a_sensor_in_range, clk, active_sensor != 2'd3, "sensor code 3 reached")
    `URS_ASSERT_ALWAYS(a_high_is_driven, clk, !trigger_high || trigger_driven, "high not driven")
    `URS_ASSERT(a_store_not_driven, clk, rst_n, distance_valid |-> !trigger_driven, "store while driving")
    `URS_ASSERT(a_high_then_low, clk, rst_n, (step && trigger_high) |=> (trigger_driven && !trigger_high), "trigger pulse too long")

endmodule
